>>> hw/rtl/pnc_pkg.sv
// Shared types and constants for the nearest palette color match block.
// No dependencies; imported by pnc_store, pnc_dist and the top level.
`default_nettype none

package pnc_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int SIZE_W      = 9;
  localparam int CHAN_W      = 8;
  localparam int RGB_W       = 3 * CHAN_W;
  localparam int SQ_W        = 2 * CHAN_W;
  localparam int DIST_W      = SQ_W + 2;

  // Above any reachable distance, so entry 0 always takes the lead
  localparam logic [DIST_W-1:0] SEARCH_LIMIT = DIST_W'(200000);

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_MATCH = 1'b1;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [RGB_W-1:0]  data;
  } pnc_wr_t;

  typedef struct packed {
    logic              en;
    logic [SIZE_W-1:0] bound;
  } pnc_clr_t;

endpackage

`default_nettype wire

>>> hw/rtl/palette_nearest_colour_match.sv
// Nearest palette color match: palette store plus one shared distance/compare unit.
// Write request: no result. Match request: one memory read per entry of the effective
// palette size n (0..256); read data, squared differences and running minimum are registered
// before the result reaches the output register.
// Next request is taken once the result is handed to the output register.
// Reset: palette size 0, all entries read as zero through cleared valid bits; no clearing pass.
`default_nettype none

module palette_nearest_colour_match (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [pnc_pkg::SIZE_W-1:0]     palette_size,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire                           req_type,
  input  wire [pnc_pkg::ADDR_W-1:0]     entry_index,
  input  wire [pnc_pkg::CHAN_W-1:0]     red,
  input  wire [pnc_pkg::CHAN_W-1:0]     green,
  input  wire [pnc_pkg::CHAN_W-1:0]     blue,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [pnc_pkg::ADDR_W-1:0]    best_index
);
  import pnc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_ENTRIES);

  state_t            state;
  state_t            state_next;
  logic [SIZE_W-1:0] pal_size;
  logic [SIZE_W-1:0] eff;
  logic [SIZE_W-1:0] cfg_eff;
  logic [SIZE_W-1:0] cnt;
  logic [RGB_W-1:0]  target;
  logic [ADDR_W-1:0] rd_idx;
  logic              rd_v;
  logic [RGB_W-1:0]  rd_data;
  logic              accept;
  logic              start;
  logic              issue;
  logic              scan_end;
  logic              load;
  logic              busy;
  logic [ADDR_W-1:0] best;
  pnc_wr_t           wr;
  pnc_clr_t          clr;

  assign cfg_ready = 1'b1;
  assign eff       = (pal_size > MAX_SIZE) ? MAX_SIZE : pal_size;
  assign cfg_eff   = (palette_size > MAX_SIZE) ? MAX_SIZE : palette_size;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign start    = accept && (req_type == REQ_MATCH);
  assign issue    = (state == ST_SCAN) && (cnt < eff);
  assign scan_end = (state == ST_SCAN) && !issue && !rd_v && !busy;
  assign load     = (state == ST_FIN) && (!out_valid || out_ready);

  always_comb begin
    wr.en   = accept && (req_type == REQ_WRITE) && ({1'b0, entry_index} < eff);
    wr.addr = entry_index;
    wr.data = {red, green, blue};
    // entries at or above the new size are zeroed
    clr.en    = cfg_valid && cfg_ready;
    clr.bound = cfg_eff;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_SCAN;
      ST_SCAN: if (scan_end) state_next = ST_FIN;
      ST_FIN:  if (load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pal_size  <= '0;
      cnt       <= '0;
      rd_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        pal_size <= palette_size;
      end
      if (start) begin
        cnt <= '0;
      end else if (issue) begin
        cnt <= cnt + SIZE_W'(1);
      end
      rd_v <= issue;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      target <= {red, green, blue};
    end
    rd_idx <= cnt[ADDR_W-1:0];
    if (load) begin
      best_index <= best;
    end
  end

  pnc_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .clr     (clr),
    .rd_en   (issue),
    .rd_addr (cnt[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  pnc_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .target  (target),
    .smp_v   (rd_v),
    .smp_idx (rd_idx),
    .smp_rgb (rd_data),
    .busy    (busy),
    .best    (best)
  );

endmodule

`default_nettype wire

>>> hw/rtl/pnc_store.sv
// Palette storage: one-write/one-read memory with registered read data.
// Per-entry valid bits make unwritten or cleared entries read as zero. Uses pnc_pkg.
`default_nettype none

module pnc_store (
  input  wire                           clk,
  input  wire                           rst,
  input  pnc_pkg::pnc_wr_t              wr,
  input  pnc_pkg::pnc_clr_t             clr,
  input  wire                           rd_en,
  input  wire [pnc_pkg::ADDR_W-1:0]     rd_addr,
  output logic [pnc_pkg::RGB_W-1:0]     rd_data
);
  import pnc_pkg::*;

  logic [RGB_W-1:0]       mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] vld;
  logic [RGB_W-1:0]       rd_raw;
  logic                   rd_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      // drop every entry at or above the new bound
      if (clr.en) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if ((SIZE_W+1)'(i) >= {1'b0, clr.bound}) begin
            vld[i] <= 1'b0;
          end
        end
      end
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_raw : '0;

endmodule

`default_nettype wire

>>> hw/rtl/pnc_dist.sv
// Shared distance unit: squared channel differences, then sum and running minimum.
// Two stages, one palette entry per cycle. Uses pnc_pkg.
`default_nettype none

module pnc_dist (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  input  wire [pnc_pkg::RGB_W-1:0]      target,
  input  wire                           smp_v,
  input  wire [pnc_pkg::ADDR_W-1:0]     smp_idx,
  input  wire [pnc_pkg::RGB_W-1:0]      smp_rgb,
  output logic                          busy,
  output logic [pnc_pkg::ADDR_W-1:0]    best
);
  import pnc_pkg::*;

  logic [SQ_W-1:0]   sq [3];
  logic [ADDR_W-1:0] sq_idx;
  logic              sq_v;
  logic [DIST_W-1:0] min_d;
  logic [DIST_W-1:0] sum;
  logic [CHAN_W-1:0] ad [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [CHAN_W-1:0] a;
      logic [CHAN_W-1:0] b;
      a = smp_rgb[c*CHAN_W +: CHAN_W];
      b = target[c*CHAN_W +: CHAN_W];
      ad[c] = (a > b) ? (a - b) : (b - a);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v <= 1'b0;
    end else begin
      sq_v <= smp_v;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      sq[c] <= ad[c] * ad[c];
    end
    sq_idx <= smp_idx;
  end

  assign sum = DIST_W'(sq[0]) + DIST_W'(sq[1]) + DIST_W'(sq[2]);

  // strict less-than keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (start) begin
      min_d <= SEARCH_LIMIT;
      best  <= '0;
    end else if (sq_v && (sum < min_d)) begin
      min_d <= sum;
      best  <= sq_idx;
    end
  end

  assign busy = sq_v;

endmodule

`default_nettype wire

>>> tb/palette_nearest_colour_match_tb.sv
// Self-checking testbench for palette_nearest_colour_match: directed and random palette
// writes, size changes and colour matches, checked against an in-bench palette predictor.
// Depends on pnc_pkg and the palette_nearest_colour_match RTL.
`default_nettype none

module palette_nearest_colour_match_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pnc_pkg::*;

  localparam int IDLE_LIMIT    = 5000;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 10;
  localparam int REPORT_MAX    = 10;
  localparam int NUM_PHASES    = 14;

  typedef enum int {READY_ALWAYS, READY_HALF, READY_RARE} ready_mode_t;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [SIZE_W-1:0]    palette_size = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_ready;
  logic                 req_type     = REQ_WRITE;
  logic [ADDR_W-1:0]    entry_index  = '0;
  logic [CHAN_W-1:0]    red          = '0;
  logic [CHAN_W-1:0]    green        = '0;
  logic [CHAN_W-1:0]    blue         = '0;
  logic                 out_valid;
  logic                 out_ready    = 1'b0;
  logic [ADDR_W-1:0]    best_index;

  // Palette predictor state
  logic [RGB_W-1:0]     palette_model [MAX_ENTRIES];
  logic [SIZE_W-1:0]    size_setting;
  logic [ADDR_W-1:0]    expected_index [$];

  int mismatch_count  = 0;
  int results_checked = 0;
  int matches_sent    = 0;
  int writes_sent     = 0;
  int size_writes     = 0;
  int idle_cycles     = 0;

  // Receiver hold-off control: the test bumps hold_seq, the receiver counts the hold
  int          hold_seq   = 0;
  int          hold_seen  = 0;
  int          hold_left  = 0;
  ready_mode_t ready_mode = READY_ALWAYS;
  int          mode_left  = 0;

  palette_nearest_colour_match uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .palette_size (palette_size),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .entry_index  (entry_index),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .best_index   (best_index)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int active_entries(logic [SIZE_W-1:0] s);
    return (int'(s) > MAX_ENTRIES) ? MAX_ENTRIES : int'(s);
  endfunction

  function automatic int channel_dist(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
    int d;
    d = int'(a) - int'(b);
    return d * d;
  endfunction

  function automatic logic [ADDR_W-1:0] nearest_entry(logic [CHAN_W-1:0] r,
                                                      logic [CHAN_W-1:0] g,
                                                      logic [CHAN_W-1:0] b);
    int               n;
    int               best;
    int               min_dist;
    int               sq_sum;
    logic [RGB_W-1:0] e;
    n        = active_entries(size_setting);
    best     = 0;
    min_dist = int'(SEARCH_LIMIT);
    for (int i = 0; i < n; i++) begin
      e      = palette_model[i];
      sq_sum = channel_dist(e[23:16], r) + channel_dist(e[15:8], g) + channel_dist(e[7:0], b);
      // strict compare keeps the lowest index on a tie
      if (sq_sum < min_dist) begin
        min_dist = sq_sum;
        best     = i;
      end
    end
    return ADDR_W'(best);
  endfunction

  // Entries at or above the smaller of old and new size are cleared
  function automatic void resize_palette(logic [SIZE_W-1:0] s);
    int keep;
    keep = active_entries(size_setting);
    if (active_entries(s) < keep) keep = active_entries(s);
    size_setting = s;
    for (int i = keep; i < MAX_ENTRIES; i++) palette_model[i] = '0;
  endfunction

  function automatic logic [CHAN_W-1:0] pick_channel();
    logic [CHAN_W-1:0] corners [6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    if ($urandom_range(0, 3) == 0) return corners[$urandom_range(0, 5)];
    return CHAN_W'($urandom_range(0, 255));
  endfunction

  function automatic void note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  task automatic send_request(input logic kind, input logic [ADDR_W-1:0] idx,
                              input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b);
    in_valid    <= 1'b1;
    req_type    <= kind;
    entry_index <= idx;
    red         <= r;
    green       <= g;
    blue        <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind == REQ_MATCH) begin
      expected_index.push_back(nearest_entry(r, g, b));
      matches_sent++;
    end else begin
      writes_sent++;
      if (int'(idx) < active_entries(size_setting)) palette_model[idx] = {r, g, b};
    end
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop valid, wait for every outstanding result, then let a trailing write settle
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (expected_index.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_palette_size(input logic [SIZE_W-1:0] s);
    wait_results_drained();
    cfg_valid    <= 1'b1;
    palette_size <= s;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    resize_palette(s);
    size_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic match_colour(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b);
    send_request(REQ_MATCH, ADDR_W'($urandom_range(0, 255)), r, g, b);
  endtask

  task automatic test_empty_palette();
    match_colour(8'd0, 8'd0, 8'd0);
    match_colour(8'd255, 8'd255, 8'd255);
    send_request(REQ_WRITE, 8'd0, 8'd9, 8'd9, 8'd9);
    match_colour(8'd9, 8'd9, 8'd9);
    set_palette_size(9'd0);
    match_colour(8'd128, 8'd128, 8'd128);
  endtask

  task automatic test_directed_matches();
    set_palette_size(9'd4);
    send_request(REQ_WRITE, 8'd0, 8'd0, 8'd0, 8'd0);
    // all entries equal: lowest index wins
    match_colour(8'd255, 8'd255, 8'd255);
    send_request(REQ_WRITE, 8'd1, 8'd255, 8'd255, 8'd255);
    send_request(REQ_WRITE, 8'd2, 8'd255, 8'd0, 8'd0);
    send_request(REQ_WRITE, 8'd3, 8'd255, 8'd255, 8'd255);
    match_colour(8'd255, 8'd255, 8'd255);
    match_colour(8'd250, 8'd10, 8'd5);
    // writes past the palette size are dropped
    send_request(REQ_WRITE, 8'd4, 8'd250, 8'd10, 8'd5);
    send_request(REQ_WRITE, 8'd255, 8'd7, 8'd7, 8'd7);
    match_colour(8'd250, 8'd10, 8'd5);
    match_colour(8'd128, 8'd128, 8'd128);
    match_colour(8'd0, 8'd255, 8'd0);
  endtask

  task automatic test_search_start();
    set_palette_size(9'd1);
    send_request(REQ_WRITE, 8'd0, 8'd0, 8'd0, 8'd0);
    // largest possible distance must still beat the initial minimum
    match_colour(8'd255, 8'd255, 8'd255);
  endtask

  task automatic test_resizing();
    set_palette_size(9'd4);
    send_request(REQ_WRITE, 8'd3, 8'd200, 8'd200, 8'd200);
    send_request(REQ_WRITE, 8'd1, 8'd100, 8'd100, 8'd100);
    set_palette_size(9'd2);
    set_palette_size(9'd4);
    match_colour(8'd200, 8'd200, 8'd200);
  endtask

  task automatic test_oversized_size();
    set_palette_size(9'd511);
    send_request(REQ_WRITE, 8'd255, 8'd255, 8'd255, 8'd255);
    match_colour(8'd255, 8'd255, 8'd255);
    set_palette_size(9'd257);
    match_colour(8'd254, 8'd254, 8'd254);
    set_palette_size(9'd256);
  endtask

  // Returns whether the item did anything (out-of-range writes are ignored by the block)
  task automatic random_item(input int n_active, output bit counted);
    int               roll;
    logic [ADDR_W-1:0] idx;
    logic [RGB_W-1:0]  e;
    roll = $urandom_range(0, 99);
    if (roll >= 90) begin
      idx = ADDR_W'($urandom_range(0, 255));
      counted = (int'(idx) < n_active);
      send_request(REQ_WRITE, idx, pick_channel(), pick_channel(), pick_channel());
    end else if (n_active == 0 || roll < 35) begin
      counted = 1'b1;
      if (n_active > 0 && roll < 10) begin
        // aim at a stored colour to provoke exact hits and ties
        e = palette_model[$urandom_range(0, n_active - 1)];
        match_colour(e[23:16], e[15:8], e[7:0]);
      end else begin
        match_colour(pick_channel(), pick_channel(), pick_channel());
      end
    end else begin
      counted = 1'b1;
      send_request(REQ_WRITE, ADDR_W'($urandom_range(0, n_active - 1)),
                   pick_channel(), pick_channel(), pick_channel());
    end
  endtask

  task automatic test_random_traffic();
    int  phase_size  [NUM_PHASES] = '{1, 2, 3, 8, 16, 37, 64, 128, 200, 256, 300, 511, 5, 0};
    int  phase_items [NUM_PHASES] = '{120, 120, 120, 150, 150, 120, 100, 80, 60, 60, 40, 40,
                                      120, 30};
    int  done;
    int  burst;
    bit  gaps_on;
    bit  counted;
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_palette_size(SIZE_W'(phase_size[p]));
      gaps_on = ($urandom_range(0, 3) != 0);
      burst   = $urandom_range(1, 8);
      done    = 0;
      while (done < phase_items[p]) begin
        random_item(active_entries(size_setting), counted);
        if (counted) done++;
        burst--;
        if (burst == 0) begin
          if (gaps_on) pause_sender($urandom_range(1, 12));
          burst = $urandom_range(1, 8);
        end
      end
    end
  endtask

  task automatic test_backpressure();
    set_palette_size(9'd16);
    hold_seq <= hold_seq + 1;
    // keep offering while the output is held off so the input stalls
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 0)
        send_request(REQ_WRITE, ADDR_W'($urandom_range(0, 15)),
                     pick_channel(), pick_channel(), pick_channel());
      else
        match_colour(pick_channel(), pick_channel(), pick_channel());
    end
    wait_results_drained();
    for (int i = 0; i < 8; i++) match_colour(pick_channel(), pick_channel(), pick_channel());
  endtask

  // Result receiver
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= ready_mode_t'($urandom_range(0, 2));
        mode_left  <= $urandom_range(16, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_HALF:   out_ready <= 1'($urandom_range(0, 1));
        default:      out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_index.size() == 0) begin
        note_failure($sformatf("unexpected result best_index=%0d", best_index));
      end else begin
        results_checked++;
        if (best_index !== expected_index[0])
          note_failure($sformatf("best_index expected %0d, got %0d",
                                 expected_index[0], best_index));
        void'(expected_index.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Timeout: no progress for %0d cycles", IDLE_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    foreach (palette_model[i]) palette_model[i] = '0;
    size_setting = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_palette();
    test_directed_matches();
    test_search_start();
    test_resizing();
    test_oversized_size();
    test_random_traffic();
    test_backpressure();
    wait_results_drained();

    $display("Run covered %0d palette writes, %0d colour matches and %0d size changes",
             writes_sent, matches_sent, size_writes);
    $display("%0d results checked, %0d failures", results_checked, mismatch_count);
    if (mismatch_count == 0 && expected_index.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
